// ===== rtl/psrl_pkg.sv =====
`default_nettype none
// ============================================================================
// psrl_pkg
// Types and constants shared by the per-source rate limit filter.
// ============================================================================
package psrl_pkg;

    // Header field codes
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;

    // Counter and register widths
    localparam int COUNT_W = 17;
    localparam int TIME_W  = 64;
    localparam int DUR_W   = 40;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 40;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_NS      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_DURATION = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARDED_PORT   = 8'd3;

    // Register values after reset
    localparam logic [15:0]      RATE_LIMIT_RST     = 16'd5000;
    localparam logic [DUR_W-1:0] WINDOW_NS_RST      = 40'd1000000000;
    localparam logic [DUR_W-1:0] BLOCK_DURATION_RST = 40'd60000000000;
    localparam logic [15:0]      GUARDED_PORT_RST   = 16'd51820;

    // Verdict causes
    typedef enum logic [1:0] {
        CAUSE_PASS      = 2'd0,
        CAUSE_BLOCKED   = 2'd1,
        CAUSE_RATE      = 2'd2,
        CAUSE_TRUNC_TCP = 2'd3
    } cause_t;

    // One parsed header, as presented on the command port
    typedef struct packed {
        logic [TIME_W-1:0] now_ns;
        logic              eth_complete;
        logic [15:0]       ether_type;
        logic              ip_complete;
        logic [7:0]        ip_protocol;
        logic              l4_complete;
        logic [31:0]       src_ip;
        logic [15:0]       dst_port;
    } in_beat_t;

    // One verdict
    typedef struct packed {
        logic   drop;
        cause_t cause;
    } out_beat_t;

    // Rate table entry
    typedef struct packed {
        logic               valid;
        logic [31:0]        key;
        logic [TIME_W-1:0]  window_start;
        logic [COUNT_W-1:0] count;
    } rate_entry_t;

    // Block table entry
    typedef struct packed {
        logic              valid;
        logic [31:0]       key;
        logic [TIME_W-1:0] expiry;
    } block_entry_t;

    // Table write requests from the verdict logic
    typedef struct packed {
        logic        en;
        rate_entry_t entry;
    } rate_wr_t;

    typedef struct packed {
        logic         en;
        block_entry_t entry;
    } block_wr_t;

endpackage : psrl_pkg
`default_nettype wire

// ===== rtl/psrl_verdict.sv =====
`default_nettype none
// ============================================================================
// psrl_verdict
// Decides the verdict for one header from its table entries and builds the
// updated rate and block entries.
// ============================================================================
module psrl_verdict (
    input  wire  psrl_pkg::in_beat_t                 item,
    input  wire  logic [psrl_pkg::TIME_W-1:0]        expiry,
    input  wire  psrl_pkg::rate_entry_t              rate_rd,
    input  wire  psrl_pkg::block_entry_t             block_rd,
    input  wire  logic [15:0]                        rate_limit,
    input  wire  logic [psrl_pkg::DUR_W-1:0]         window_ns,
    input  wire  logic [15:0]                        guarded_udp_port,
    output psrl_pkg::rate_wr_t                       rate_wr,
    output psrl_pkg::block_wr_t                      block_wr,
    output psrl_pkg::out_beat_t                      verdict
);

    logic                                 is_ip;
    logic                                 block_hit;
    logic                                 blocked;
    logic                                 is_tcp;
    logic                                 is_udp;
    logic                                 counted;
    logic                                 trunc_tcp;
    logic                                 rate_hit;
    logic [psrl_pkg::TIME_W-1:0]          age;
    logic                                 elapsed;
    logic                                 restart;
    logic [psrl_pkg::COUNT_W-1:0]         count_inc;
    logic                                 over;
    psrl_pkg::cause_t                     cause;

    // Classify the header and check the block list.
    always_comb
    begin
        is_ip     = item.eth_complete && (item.ether_type == psrl_pkg::ETH_TYPE_IPV4)
                    && item.ip_complete;
        block_hit = block_rd.valid && (block_rd.key == item.src_ip);
        blocked   = is_ip && block_hit && (item.now_ns < block_rd.expiry);
        is_tcp    = item.ip_protocol == psrl_pkg::PROTO_TCP;
        is_udp    = item.ip_protocol == psrl_pkg::PROTO_UDP;
        counted   = is_ip && !blocked && item.l4_complete
                    && (is_tcp || (is_udp && (item.dst_port == guarded_udp_port)));
        trunc_tcp = is_ip && !blocked && is_tcp && !item.l4_complete;
    end

    // Fixed-window count for the source.
    always_comb
    begin
        rate_hit  = rate_rd.valid && (rate_rd.key == item.src_ip);
        age       = item.now_ns - rate_rd.window_start;
        elapsed   = age > {{(psrl_pkg::TIME_W - psrl_pkg::DUR_W){1'b0}}, window_ns};
        restart   = !rate_hit || elapsed;
        count_inc = (rate_rd.count == psrl_pkg::COUNT_MAX) ? rate_rd.count
                    : rate_rd.count + psrl_pkg::COUNT_W'(1);
        over      = !restart && (count_inc > {1'b0, rate_limit});
    end

    // Table updates. A new block overrides the removal of an expired one.
    always_comb
    begin
        rate_wr.en                 = counted;
        rate_wr.entry.valid        = 1'b1;
        rate_wr.entry.key          = item.src_ip;
        rate_wr.entry.window_start = restart ? item.now_ns : rate_rd.window_start;
        rate_wr.entry.count        = restart ? psrl_pkg::COUNT_W'(1) : count_inc;

        block_wr.en           = (counted && over) || (is_ip && block_hit && !blocked);
        block_wr.entry.valid  = counted && over;
        block_wr.entry.key    = item.src_ip;
        block_wr.entry.expiry = expiry;
    end

    // Verdict and cause.
    always_comb
    begin
        priority if (blocked)
            cause = psrl_pkg::CAUSE_BLOCKED;
        else if (trunc_tcp)
            cause = psrl_pkg::CAUSE_TRUNC_TCP;
        else if (counted && over)
            cause = psrl_pkg::CAUSE_RATE;
        else
            cause = psrl_pkg::CAUSE_PASS;
        verdict.cause = cause;
        verdict.drop  = cause != psrl_pkg::CAUSE_PASS;
    end

endmodule : psrl_verdict
`default_nettype wire

// ===== rtl/per_source_rate_limit_filter.sv =====
`default_nettype none
// ============================================================================
// per_source_rate_limit_filter
// Per-source fixed-window rate limiter with a block list over parsed headers.
// ============================================================================
// Usage:
//   Command port: present a parsed header on item with start high; it is
//   taken at a clock edge where start is high and busy is low.
//   The verdict is on verdict for exactly one cycle with verdict_valid high:
//   it is registered through the read stage (item_reg and the table read
//   registers) and then verdict_reg. No stall possible.
//   A new header is not taken before the last is written back: the rate and
//   block tables are read at the edge that takes the header and written back
//   at the next edge, and busy stays high over that read-modify-write.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//   always high. Indexes 0..3 are rate_limit, window_ns, block_duration_ns,
//   guarded_udp_port; other indexes are ignored. Write only while idle.
//   Tables are direct mapped on the low bits of src_ip; both depths must be
//   powers of two.
//   Reset: registers return to their defaults, then a clearing pass over
//   max(RATE_ENTRIES, BLOCK_ENTRIES) table indexes (1024 by default) invalidates
//   both tables; busy is high during the pass.
// ============================================================================
module per_source_rate_limit_filter #(
    parameter int RATE_ENTRIES  = 1024,
    parameter int BLOCK_ENTRIES = 256
) (
    input  wire  logic                                 clk,
    input  wire  logic                                 rst_n,
    input  wire  logic                                 start,
    output logic                                       busy,
    input  wire  psrl_pkg::in_beat_t                   item,
    output logic                                       verdict_valid,
    output psrl_pkg::out_beat_t                        verdict,
    input  wire  logic                                 cfg_valid,
    output logic                                       cfg_ready,
    input  wire  logic [psrl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  logic [psrl_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int RATE_AW = $clog2(RATE_ENTRIES);
    localparam int BLOCK_AW = $clog2(BLOCK_ENTRIES);
    localparam int SWEEP_DEPTH = (RATE_ENTRIES > BLOCK_ENTRIES) ? RATE_ENTRIES : BLOCK_ENTRIES;
    localparam int MAX_AW = $clog2(SWEEP_DEPTH);

    // Configuration registers
    logic [15:0]                   rate_limit_reg;
    logic [psrl_pkg::DUR_W-1:0]    window_ns_reg;
    logic [psrl_pkg::DUR_W-1:0]    block_duration_reg;
    logic [15:0]                   guarded_port_reg;

    // Control
    logic                          clearing_reg;
    logic [MAX_AW-1:0]             clr_idx_reg;
    logic                          stage_valid_reg;
    logic                          verdict_valid_reg;
    logic                          accept;

    // Stage payload
    psrl_pkg::in_beat_t            item_reg;
    logic [psrl_pkg::TIME_W-1:0]   expiry_reg;
    logic [psrl_pkg::TIME_W:0]     expiry_sum;
    logic [psrl_pkg::TIME_W-1:0]   expiry_next;
    psrl_pkg::out_beat_t           verdict_reg;

    // Tables
    psrl_pkg::rate_entry_t         rate_mem [RATE_ENTRIES];
    psrl_pkg::block_entry_t        block_mem [BLOCK_ENTRIES];
    psrl_pkg::rate_entry_t         rate_rd_reg;
    psrl_pkg::block_entry_t        block_rd_reg;
    psrl_pkg::rate_wr_t            rate_wr;
    psrl_pkg::block_wr_t           block_wr;
    psrl_pkg::out_beat_t           verdict_next;
    logic                          clr_rate;
    logic                          clr_block;

    assign accept        = start && !busy;
    assign busy          = clearing_reg || stage_valid_reg;
    assign cfg_ready     = 1'b1;
    assign verdict_valid = verdict_valid_reg;
    assign verdict       = verdict_reg;

    // Configuration writes; widths beyond the register are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_limit_reg     <= psrl_pkg::RATE_LIMIT_RST;
            window_ns_reg      <= psrl_pkg::WINDOW_NS_RST;
            block_duration_reg <= psrl_pkg::BLOCK_DURATION_RST;
            guarded_port_reg   <= psrl_pkg::GUARDED_PORT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                psrl_pkg::CFG_RATE_LIMIT:     rate_limit_reg     <= cfg_data[15:0];
                psrl_pkg::CFG_WINDOW_NS:      window_ns_reg      <= cfg_data;
                psrl_pkg::CFG_BLOCK_DURATION: block_duration_reg <= cfg_data;
                psrl_pkg::CFG_GUARDED_PORT:   guarded_port_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Clearing pass after reset and the control pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg      <= 1'b1;
            clr_idx_reg       <= '0;
            stage_valid_reg   <= 1'b0;
            verdict_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_reg + MAX_AW'(1);
                if (clr_idx_reg == MAX_AW'(SWEEP_DEPTH - 1))
                    clearing_reg <= 1'b0;
            end
            stage_valid_reg   <= accept;
            verdict_valid_reg <= stage_valid_reg;
        end
    end

    // Block expiry, saturated at the top of the time range.
    always_comb
    begin
        expiry_sum  = {1'b0, item.now_ns}
                      + {{(psrl_pkg::TIME_W + 1 - psrl_pkg::DUR_W){1'b0}}, block_duration_reg};
        expiry_next = expiry_sum[psrl_pkg::TIME_W] ? {psrl_pkg::TIME_W{1'b1}}
                      : expiry_sum[psrl_pkg::TIME_W-1:0];
    end

    // Capture the header beat and read both tables.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg     <= item;
            expiry_reg   <= expiry_next;
            rate_rd_reg  <= rate_mem[item.src_ip[RATE_AW-1:0]];
            block_rd_reg <= block_mem[item.src_ip[BLOCK_AW-1:0]];
        end
        if (stage_valid_reg)
            verdict_reg <= verdict_next;
    end

    // Verdict logic between the read registers and the verdict register.
    psrl_verdict u_verdict (
        .item             (item_reg),
        .expiry           (expiry_reg),
        .rate_rd          (rate_rd_reg),
        .block_rd         (block_rd_reg),
        .rate_limit       (rate_limit_reg),
        .window_ns        (window_ns_reg),
        .guarded_udp_port (guarded_port_reg),
        .rate_wr          (rate_wr),
        .block_wr         (block_wr),
        .verdict          (verdict_next)
    );

    // Sweep enables for each table.
    always_comb
    begin
        clr_rate  = clearing_reg && ({1'b0, clr_idx_reg} < (MAX_AW + 1)'(RATE_ENTRIES));
        clr_block = clearing_reg && ({1'b0, clr_idx_reg} < (MAX_AW + 1)'(BLOCK_ENTRIES));
    end

    // Table writes: clearing pass, or the write-back of the current header.
    always_ff @(posedge clk)
    begin
        if (clr_rate)
            rate_mem[clr_idx_reg[RATE_AW-1:0]] <= '0;
        else if (stage_valid_reg && rate_wr.en)
            rate_mem[item_reg.src_ip[RATE_AW-1:0]] <= rate_wr.entry;
        if (clr_block)
            block_mem[clr_idx_reg[BLOCK_AW-1:0]] <= '0;
        else if (stage_valid_reg && block_wr.en)
            block_mem[item_reg.src_ip[BLOCK_AW-1:0]] <= block_wr.entry;
    end

`ifndef SYNTHESIS
    // A taken header always gives its verdict, by way of stage_valid_reg and verdict_valid_reg.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 verdict_valid)
        else $error("verdict missing two cycles after a header beat");

    // Verdicts never come back to back.
    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid |=> !verdict_valid)
        else $error("verdict strobe held for two cycles");

    // Drop flag agrees with the cause.
    a_drop_cause: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid |-> (verdict.drop == (verdict.cause != psrl_pkg::CAUSE_PASS)))
        else $error("drop flag disagrees with cause");

    // No verdict can come out of the clearing pass.
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !stage_valid_reg && !verdict_valid)
        else $error("header processed during table clearing");
`endif

endmodule : per_source_rate_limit_filter
`default_nettype wire
